// ===== sv/tphc_pkg.sv =====
package tphc_pkg;

    localparam int HEADER_BYTES = 20;
    localparam int CHECK_OFFSET = 16;
    localparam int OFFSET_W     = 6;
    localparam int QUEUE_DEPTH  = 2;
    localparam int PSEUDO_WORDS = 3;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_TCP4  = 2'd1;
    localparam logic [1:0] MODE_TCP6  = 2'd2;

    localparam logic [1:0] SEC_SRC     = 2'd0;
    localparam logic [1:0] SEC_DST     = 2'd1;
    localparam logic [1:0] SEC_HDR     = 2'd2;
    localparam logic [1:0] SEC_PAYLOAD = 2'd3;

    localparam logic CFG_MODE     = 1'b0;
    localparam logic CFG_PROTOCOL = 1'b1;

    localparam logic [7:0] PROTOCOL_RESET = 8'd6;

    typedef struct packed {
        logic                               start;
        logic [15:0]                        init;
        logic [15:0]                        word;
        logic                               last;
        logic [1:0]                         pcount;
        logic [PSEUDO_WORDS-1:0][15:0]      pword;
        logic                               overflow;
    } entry_t;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ===== sv/tphc_front.sv =====
module tphc_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic [1:0]           section,
    input  logic [31:0]          seed,
    input  logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 full,
    output logic                 push,
    output tphc_pkg::entry_t     push_entry
);

    localparam logic [tphc_pkg::OFFSET_W-1:0] HDR_BOUND =
        tphc_pkg::OFFSET_W'(tphc_pkg::HEADER_BYTES);
    localparam logic [tphc_pkg::OFFSET_W-1:0] CHK0 =
        tphc_pkg::OFFSET_W'(tphc_pkg::CHECK_OFFSET);
    localparam logic [tphc_pkg::OFFSET_W-1:0] CHK1 =
        tphc_pkg::OFFSET_W'(tphc_pkg::CHECK_OFFSET + 1);

    logic [1:0]                      mode_reg;
    logic [7:0]                      protocol_reg;
    logic                            started_reg;
    logic                            odd_reg;
    logic [7:0]                      pend_reg;
    logic [31:0]                     len_reg;
    logic [tphc_pkg::OFFSET_W-1:0]   hoff_reg;

    logic                            tcp;
    logic                            is_hdr;
    logic                            counted;
    logic                            zero_byte;
    logic [7:0]                      byte_v;
    logic [tphc_pkg::OFFSET_W-1:0]   hoff_next;
    logic [31:0]                     len_next;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign push      = in_valid && !full;

    always_comb
    begin
        tcp       = (mode_reg == tphc_pkg::MODE_TCP4) || (mode_reg == tphc_pkg::MODE_TCP6);
        is_hdr    = tcp && (section == tphc_pkg::SEC_HDR);
        counted   = tcp && ((section == tphc_pkg::SEC_HDR) || (section == tphc_pkg::SEC_PAYLOAD));
        zero_byte = is_hdr && (hoff_reg < HDR_BOUND) && ((hoff_reg == CHK0) || (hoff_reg == CHK1));
        byte_v    = zero_byte ? 8'h00 : data_byte;
        hoff_next = (is_hdr && (hoff_reg != '1)) ? hoff_reg + 1'b1 : hoff_reg;
        len_next  = (counted && (len_reg != '1)) ? len_reg + 32'd1 : len_reg;

        push_entry.start    = !started_reg;
        push_entry.init     = tcp ? 16'd0 : tphc_pkg::ones_add(seed[15:0], seed[31:16]);
        push_entry.last     = last;
        push_entry.word     = odd_reg ? {pend_reg, byte_v} : (last ? {byte_v, 8'h00} : 16'd0);
        push_entry.pcount   = 2'd0;
        push_entry.pword    = '0;
        push_entry.overflow = 1'b0;
        if (last)
        begin
            case (mode_reg)
                tphc_pkg::MODE_TCP4:
                begin
                    push_entry.pcount   = 2'd2;
                    push_entry.pword[0] = {8'h00, protocol_reg};
                    push_entry.pword[1] = len_next[15:0];
                    push_entry.overflow = |len_next[31:16];
                end
                tphc_pkg::MODE_TCP6:
                begin
                    push_entry.pcount   = 2'd3;
                    push_entry.pword[0] = len_next[31:16];
                    push_entry.pword[1] = len_next[15:0];
                    push_entry.pword[2] = {8'h00, protocol_reg};
                end
                default:
                begin
                    push_entry.pcount = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= tphc_pkg::MODE_PLAIN;
            protocol_reg <= tphc_pkg::PROTOCOL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tphc_pkg::CFG_MODE:     mode_reg     <= cfg_data[1:0];
                tphc_pkg::CFG_PROTOCOL: protocol_reg <= cfg_data;
                default:                mode_reg     <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            odd_reg     <= 1'b0;
            pend_reg    <= 8'h00;
            len_reg     <= 32'd0;
            hoff_reg    <= '0;
        end
        else if (push)
        begin
            if (last)
            begin
                started_reg <= 1'b0;
                odd_reg     <= 1'b0;
                pend_reg    <= 8'h00;
                len_reg     <= 32'd0;
                hoff_reg    <= '0;
            end
            else
            begin
                started_reg <= 1'b1;
                odd_reg     <= !odd_reg;
                pend_reg    <= odd_reg ? 8'h00 : byte_v;
                len_reg     <= len_next;
                hoff_reg    <= hoff_next;
            end
        end
    end

endmodule

// ===== sv/tphc_queue.sv =====
module tphc_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tphc_pkg::entry_t     push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output tphc_pkg::entry_t     head
);

    localparam int PTR_W = (tphc_pkg::QUEUE_DEPTH > 1) ? $clog2(tphc_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tphc_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(tphc_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(tphc_pkg::QUEUE_DEPTH - 1);

    tphc_pkg::entry_t      mem [tphc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_P) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_P) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

endmodule

// ===== sv/tphc_back.sv =====
module tphc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  tphc_pkg::entry_t     head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [15:0]          checksum,
    output logic                 length_overflow
);

    logic [15:0] acc_reg;
    logic [1:0]  step_reg;
    logic        out_valid_reg;
    logic [15:0] checksum_reg;
    logic        overflow_reg;

    logic [15:0] base;
    logic [15:0] operand;
    logic [15:0] sum;
    logic        final_step;
    logic        emit;
    logic        out_free;
    logic        advance;

    assign out_valid       = out_valid_reg;
    assign checksum        = checksum_reg;
    assign length_overflow = overflow_reg;

    // step 0 adds the byte pair, later steps add the pseudo-header words
    always_comb
    begin
        base       = ((step_reg == 2'd0) && head.start) ? head.init : acc_reg;
        operand    = (step_reg == 2'd0) ? head.word : head.pword[step_reg - 2'd1];
        sum        = tphc_pkg::ones_add(base, operand);
        final_step = (step_reg == head.pcount);
        emit       = head.last && final_step;
        out_free   = !out_valid_reg || !out_stall;
        advance    = head_valid && (!emit || out_free);
        pop        = advance && final_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 16'd0;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                acc_reg  <= sum;
                step_reg <= final_step ? 2'd0 : step_reg + 2'd1;
            end
            if (advance && emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            checksum_reg <= ~sum;
            overflow_reg <= head.overflow;
        end
    end

endmodule

// ===== sv/tcp_pseudo_header_checksum.sv =====
// Throughput: one byte per cycle while in_stall is low; the final byte of a TCP message holds the adder
// while the pseudo-header words go through it, so the queue can fill and raise in_stall.
// A 2-entry queue separates the byte classifier from the one's-complement adder.
// Reset (rst_n, async, active low): mode plain, protocol 6, message state cleared.
module tcp_pseudo_header_checksum
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   data_byte,
    input  logic [1:0]   section,
    input  logic [31:0]  seed,
    input  logic         last,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [15:0]  checksum,
    output logic         length_overflow,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [7:0]   cfg_data
);

    logic               push;
    logic               full;
    logic               pop;
    logic               head_valid;
    tphc_pkg::entry_t   push_entry;
    tphc_pkg::entry_t   head;

    tphc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .section    (section),
        .seed       (seed),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .full       (full),
        .push       (push),
        .push_entry (push_entry)
    );

    tphc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    tphc_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .checksum        (checksum),
        .length_overflow (length_overflow)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam logic [1:0] MODE_SPARE   = 2'd3;
    localparam int         DRAIN_CYCLES = 12;
    localparam int         CYCLE_LIMIT  = 200_000;
    localparam int         RANDOM_ITEMS = 900;
    localparam int         RANDOM_MSGS  = 48;

    typedef struct packed {
        logic [15:0] checksum;
        logic        overflow;
    } checksum_exp_t;

    logic        clk;
    logic        rst_n           = 1'b0;
    logic        in_valid        = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte       = 8'h00;
    logic [1:0]  section         = tphc_pkg::SEC_SRC;
    logic [31:0] seed            = 32'h0;
    logic        last            = 1'b0;
    logic        out_valid;
    logic        out_stall       = 1'b0;
    logic [15:0] checksum;
    logic        length_overflow;
    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    logic        cfg_index       = tphc_pkg::CFG_MODE;
    logic [7:0]  cfg_data        = 8'h00;

    // predictor copy of registers and message state
    logic [1:0]  cur_mode  = tphc_pkg::MODE_PLAIN;
    logic [7:0]  cur_proto = tphc_pkg::PROTOCOL_RESET;
    logic [15:0] run_sum   = 16'h0;
    logic [7:0]  high_byte = 8'h00;
    logic        odd_pos   = 1'b0;
    logic [31:0] seg_len   = 32'h0;
    logic [5:0]  hdr_off   = 6'd0;
    logic        started   = 1'b0;

    checksum_exp_t pending_sums[$];

    int   items_sent     = 0;
    int   msgs_done      = 0;
    int   sums_checked   = 0;
    int   mismatches     = 0;
    int   cycle_count    = 0;
    int   rx_hold        = 0;
    logic tx_idle_on     = 1'b1;
    logic rx_idle_on     = 1'b1;

    tcp_pseudo_header_checksum u_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .section         (section),
        .seed            (seed),
        .last            (last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .checksum        (checksum),
        .length_overflow (length_overflow),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAIL tcp_pseudo_header_checksum");
        $finish;
    end

    function automatic logic [15:0] add_carry(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    task automatic predict_byte(input logic [7:0] b_in, input logic [1:0] sec,
                                input logic [31:0] sd, input logic lst);
        logic [7:0]    b;
        logic          is_tcp;
        checksum_exp_t r;
        b = b_in;
        is_tcp = (cur_mode == tphc_pkg::MODE_TCP4) || (cur_mode == tphc_pkg::MODE_TCP6);
        if (!started)
        begin
            run_sum = 16'h0;
            if (!is_tcp)
            begin
                run_sum = add_carry(16'h0, sd[15:0]);
                run_sum = add_carry(run_sum, sd[31:16]);
            end
            started = 1'b1;
        end
        if (is_tcp && (sec == tphc_pkg::SEC_HDR || sec == tphc_pkg::SEC_PAYLOAD))
        begin
            if (sec == tphc_pkg::SEC_HDR)
            begin
                if (hdr_off < tphc_pkg::HEADER_BYTES &&
                    (hdr_off == tphc_pkg::CHECK_OFFSET ||
                     hdr_off == tphc_pkg::CHECK_OFFSET + 1))
                    b = 8'h00;
                if (hdr_off != '1)
                    hdr_off = hdr_off + 6'd1;
            end
            if (seg_len != '1)
                seg_len = seg_len + 32'd1;
        end
        if (odd_pos)
        begin
            run_sum   = add_carry(run_sum, {high_byte, b});
            odd_pos   = 1'b0;
            high_byte = 8'h00;
        end
        else
        begin
            high_byte = b;
            odd_pos   = 1'b1;
        end
        if (lst)
        begin
            if (odd_pos)
                run_sum = add_carry(run_sum, {high_byte, 8'h00});
            r.overflow = 1'b0;
            if (cur_mode == tphc_pkg::MODE_TCP4)
            begin
                run_sum = add_carry(run_sum, {8'h00, cur_proto});
                run_sum = add_carry(run_sum, seg_len[15:0]);
                r.overflow = (seg_len > 32'h0000_ffff);
            end
            else if (cur_mode == tphc_pkg::MODE_TCP6)
            begin
                run_sum = add_carry(run_sum, seg_len[31:16]);
                run_sum = add_carry(run_sum, seg_len[15:0]);
                run_sum = add_carry(run_sum, {8'h00, cur_proto});
            end
            r.checksum = ~run_sum;
            pending_sums.push_back(r);
            msgs_done++;
            run_sum   = 16'h0;
            high_byte = 8'h00;
            odd_pos   = 1'b0;
            seg_len   = 32'h0;
            hdr_off   = 6'd0;
            started   = 1'b0;
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [15:0] exp_sum,
                                 input logic exp_ovf);
        if (mismatches < 10)
            $display("mismatch (%s) at cycle %0d: expected sum %04h ovf %0b, %s %04h ovf %0b",
                     what, cycle_count, exp_sum, exp_ovf, "got sum", checksum,
                     length_overflow);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : result_check
        checksum_exp_t head;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_sums.size() == 0)
                    flag_mismatch("no item pending", 16'h0, 1'b0);
                else
                begin
                    head = pending_sums.pop_front();
                    if (checksum !== head.checksum || length_overflow !== head.overflow)
                        flag_mismatch("wrong value", head.checksum, head.overflow);
                end
                sums_checked++;
                rx_hold = rx_idle_on ? $urandom_range(0, 7) : 0;
            end
            if (rx_hold > 0)
            begin
                out_stall <= 1'b1;
                rx_hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic [1:0] sec,
                             input logic [31:0] sd, input logic lst);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        section   <= sec;
        seed      <= sd;
        last      <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_byte(b, sec, sd, lst);
        items_sent++;
    endtask

    // sender stops; wait for all sums, then let the pipeline empty
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == tphc_pkg::CFG_MODE)
            cur_mode = val[1:0];
        else
            cur_proto = val;
        @(posedge clk);
    endtask

    task automatic send_tcp_segment(input int addr_len, input int hdr_len, input int pay_len);
        int         total;
        logic [1:0] sec;
        total = 2 * addr_len + hdr_len + pay_len;
        for (int i = 0; i < total; i++)
        begin
            if (i < addr_len)
                sec = tphc_pkg::SEC_SRC;
            else if (i < 2 * addr_len)
                sec = tphc_pkg::SEC_DST;
            else if (i < 2 * addr_len + hdr_len)
                sec = tphc_pkg::SEC_HDR;
            else
                sec = tphc_pkg::SEC_PAYLOAD;
            send_byte(8'($urandom_range(0, 255)), sec, $urandom(), i == total - 1);
        end
    endtask

    task automatic send_noise(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)), $urandom(),
                      i == len - 1);
    endtask

    task automatic test_plain_edges();
        send_byte(8'hff, tphc_pkg::SEC_PAYLOAD, 32'hffff_ffff, 1'b1);
        send_byte(8'h00, tphc_pkg::SEC_SRC, 32'h0000_0000, 1'b1);
        send_byte(8'hab, tphc_pkg::SEC_HDR, 32'h0001_ffff, 1'b0);
        send_byte(8'hcd, tphc_pkg::SEC_DST, 32'h8000_0000, 1'b1);
        drain();
    endtask

    task automatic test_tcp4_header();
        write_reg(tphc_pkg::CFG_MODE, {6'd0, tphc_pkg::MODE_TCP4});
        // odd source byte pairs across the section boundary
        send_byte(8'hff, tphc_pkg::SEC_SRC, 32'hffff_ffff, 1'b0);
        send_byte(8'h01, tphc_pkg::SEC_DST, 32'h1234_5678, 1'b0);
        for (int i = 0; i < tphc_pkg::HEADER_BYTES - 2; i++)
            send_byte(8'hff, tphc_pkg::SEC_HDR, $urandom(), 1'b0);
        send_byte(8'h80, tphc_pkg::SEC_PAYLOAD, $urandom(), 1'b1);
        drain();
        write_reg(tphc_pkg::CFG_PROTOCOL, 8'hff);
        send_byte(8'h00, tphc_pkg::SEC_PAYLOAD, $urandom(), 1'b1);
        drain();
    endtask

    task automatic test_mode_switch();
        write_reg(tphc_pkg::CFG_MODE, {6'd0, tphc_pkg::MODE_PLAIN});
        write_reg(tphc_pkg::CFG_PROTOCOL, 8'h11);
        for (int i = 0; i < 3; i++)
            send_byte(8'($urandom_range(0, 255)), tphc_pkg::SEC_HDR, $urandom(), 1'b0);
        drain();
        write_reg(tphc_pkg::CFG_MODE, {6'd0, tphc_pkg::MODE_TCP6});
        for (int i = 0; i < 4; i++)
            send_byte(8'($urandom_range(0, 255)), tphc_pkg::SEC_HDR, $urandom(), i == 3);
        drain();
        write_reg(tphc_pkg::CFG_MODE, {6'd0, tphc_pkg::MODE_TCP4});
        for (int i = 0; i < 5; i++)
            send_byte(8'($urandom_range(0, 255)), tphc_pkg::SEC_PAYLOAD, $urandom(), 1'b0);
        drain();
        write_reg(tphc_pkg::CFG_MODE, {6'd0, MODE_SPARE});
        send_byte(8'($urandom_range(0, 255)), tphc_pkg::SEC_PAYLOAD, $urandom(), 1'b0);
        send_byte(8'($urandom_range(0, 255)), tphc_pkg::SEC_HDR, $urandom(), 1'b1);
        drain();
    endtask

    task automatic test_random_traffic();
        int         base_items;
        int         base_msgs;
        int         phase;
        int         pick;
        int         addr_len;
        int         hdr_len;
        int         pay_len;
        logic [1:0] mode_sel;
        base_items = items_sent;
        base_msgs  = msgs_done;
        phase      = 0;
        while ((items_sent - base_items) < RANDOM_ITEMS || (msgs_done - base_msgs) < RANDOM_MSGS)
        begin
            drain();
            case (phase % 4)
                0: mode_sel = tphc_pkg::MODE_PLAIN;
                1: mode_sel = tphc_pkg::MODE_TCP4;
                2: mode_sel = tphc_pkg::MODE_TCP6;
                default: mode_sel = MODE_SPARE;
            endcase
            write_reg(tphc_pkg::CFG_MODE, {6'($urandom_range(0, 63)), mode_sel});
            case (phase % 3)
                0: write_reg(tphc_pkg::CFG_PROTOCOL, 8'h00);
                1: write_reg(tphc_pkg::CFG_PROTOCOL, 8'hff);
                default: write_reg(tphc_pkg::CFG_PROTOCOL, 8'($urandom_range(0, 255)));
            endcase
            tx_idle_on = (phase % 5 != 2);
            rx_idle_on = (phase % 5 != 2);
            for (int m = 0; m < 8; m++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    addr_len = (cur_mode == tphc_pkg::MODE_TCP6) ? 16 : 4;
                    if ($urandom_range(0, 7) == 0)
                        addr_len = $urandom_range(0, 5);
                    hdr_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70)
                                                          : tphc_pkg::HEADER_BYTES;
                    pay_len = $urandom_range(0, 12);
                    if (2 * addr_len + hdr_len + pay_len == 0)
                        pay_len = 1;
                    send_tcp_segment(addr_len, hdr_len, pay_len);
                end
                else
                    send_noise($urandom_range(1, 9));
                // sender holds off until every sum is back
                if ($urandom_range(0, 5) == 0)
                begin
                    in_valid <= 1'b0;
                    while (pending_sums.size() != 0)
                        @(posedge clk);
                end
            end
            phase++;
        end
        drain();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin : main
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_edges();
        test_tcp4_header();
        test_mode_switch();
        test_random_traffic();

        drain();
        if (pending_sums.size() != 0)
        begin
            $display("%0d checksums never arrived", pending_sums.size());
            mismatches++;
        end
        $display("Sent %0d bytes in %0d messages, checked %0d checksums, %0d mismatches.",
                 items_sent, msgs_done, sums_checked, mismatches);
        $display("Modes plain/IPv4/IPv6/spare, odd lengths, mid-message mode change, long headers.");
        if (mismatches == 0)
            $display("PASS tcp_pseudo_header_checksum");
        else
            $display("FAIL tcp_pseudo_header_checksum");
        $finish;
    end

endmodule
